@@ src/crc16fc_pkg.sv @@
// ============================================================================
// crc16fc_pkg
// Shared types, constants and the CRC-16 byte step for the frame checker.
// ============================================================================
package crc16fc_pkg;

    localparam int DATA_W       = 8;
    localparam int CRC_W        = 16;
    localparam int BURST_LEN_W  = 7;
    localparam int OUT_TDATA_W  = 48;
    localparam int CFG_ADDR_W   = 3;
    localparam int CFG_DATA_W   = 32;

    localparam int FRAME_BYTES_DEF  = 39;
    localparam int BUFFER_BYTES_DEF = 64;

    localparam logic [CRC_W-1:0]  CRC_POLY       = 16'h8408;
    localparam logic [CRC_W-1:0]  CRC_SEED_RESET = 16'hFFFF;
    localparam logic [DATA_W-1:0] HEADER_FIRST   = 8'h53;   // 'S'
    localparam logic [DATA_W-1:0] HEADER_SECOND  = 8'h50;   // 'P'

    // register index (paddr[2])
    localparam logic [0:0] REG_CRC_SEED = 1'b0;

    typedef enum logic [1:0] {
        VERDICT_ACCEPTED  = 2'd0,
        VERDICT_BAD_LEN   = 2'd1,
        VERDICT_BAD_HDR   = 2'd2,
        VERDICT_BAD_CRC   = 2'd3
    } verdict_t;

    typedef struct packed {
        logic [BURST_LEN_W-1:0] burst_length;
        logic [CRC_W-1:0]       received_crc;
        logic [CRC_W-1:0]       computed_crc;
        verdict_t               verdict;
    } result_t;

    // reflected CRC-16 step, one byte
    function automatic logic [CRC_W-1:0] crc16_byte(input logic [CRC_W-1:0]  crc,
                                                    input logic [DATA_W-1:0] b);
        logic [CRC_W-1:0] x;
        x = {8'h00, crc[7:0] ^ b};
        for (int i = 0; i < 8; i++)
        begin
            x = x[0] ? ((x >> 1) ^ CRC_POLY) : (x >> 1);
        end
        return {8'h00, crc[15:8]} ^ x;
    endfunction

endpackage

@@ src/crc16fc_track.sv @@
// ============================================================================
// crc16fc_track
// Per-burst state: CRC, byte count, header flag and trailer capture, with the
// verdict formed from the next-state values of the current byte.
// ============================================================================
module crc16fc_track #(
    parameter int FRAME_BYTES  = crc16fc_pkg::FRAME_BYTES_DEF,
    parameter int BUFFER_BYTES = crc16fc_pkg::BUFFER_BYTES_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic [crc16fc_pkg::CRC_W-1:0]        seed,
    input  logic                                 advance,
    input  logic [crc16fc_pkg::DATA_W-1:0]       data_byte,
    input  logic                                 last_byte,
    output crc16fc_pkg::result_t                 result
);
    import crc16fc_pkg::*;

    localparam int CW    = $clog2(BUFFER_BYTES + 1);
    localparam int CMP_W = (CW > 7) ? CW : 7;

    localparam logic [CMP_W-1:0] CRC_END   = CMP_W'(FRAME_BYTES - 2);
    localparam logic [CMP_W-1:0] TRL_LOW   = CMP_W'(FRAME_BYTES - 2);
    localparam logic [CMP_W-1:0] TRL_HIGH  = CMP_W'(FRAME_BYTES - 1);
    localparam logic [CMP_W-1:0] FRAME_LEN = CMP_W'(FRAME_BYTES);
    localparam logic [CW-1:0]    BUF_LEN   = CW'(BUFFER_BYTES);

    logic [CRC_W-1:0] crc_reg, crc_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             header_good_reg, header_good_next;
    logic [CRC_W-1:0] trailer_reg, trailer_next;

    logic             active;
    logic [CMP_W-1:0] idx;
    logic [CRC_W-1:0] crc_base;

    always_comb
    begin
        active           = (count_reg < BUF_LEN);
        idx              = CMP_W'(count_reg);
        crc_base         = (count_reg == '0) ? seed : crc_reg;
        crc_next         = crc_reg;
        count_next       = count_reg;
        header_good_next = header_good_reg;
        trailer_next     = trailer_reg;
        if (active)
        begin
            if (idx < CRC_END)
                crc_next = crc16_byte(crc_base, data_byte);
            else
                crc_next = crc_base;
            if (idx == TRL_LOW)
                trailer_next[7:0] = data_byte;
            if (idx == TRL_HIGH)
                trailer_next[15:8] = data_byte;
            if ((idx == '0) && (data_byte != HEADER_FIRST))
                header_good_next = 1'b0;
            if ((idx == CMP_W'(1)) && (data_byte != HEADER_SECOND))
                header_good_next = 1'b0;
            count_next = count_reg + CW'(1);
        end
    end

    always_comb
    begin
        priority if (CMP_W'(count_next) != FRAME_LEN)
            result.verdict = VERDICT_BAD_LEN;
        else if (!header_good_next)
            result.verdict = VERDICT_BAD_HDR;
        else if (crc_next != trailer_next)
            result.verdict = VERDICT_BAD_CRC;
        else
            result.verdict = VERDICT_ACCEPTED;
        result.computed_crc = crc_next;
        result.received_crc = trailer_next;
        result.burst_length = BURST_LEN_W'(count_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg         <= CRC_SEED_RESET;
            count_reg       <= '0;
            header_good_reg <= 1'b1;
            trailer_reg     <= '0;
        end
        else if (advance)
        begin
            if (last_byte)
            begin
                crc_reg         <= seed;
                count_reg       <= '0;
                header_good_reg <= 1'b1;
                trailer_reg     <= '0;
            end
            else
            begin
                crc_reg         <= crc_next;
                count_reg       <= count_next;
                header_good_reg <= header_good_next;
                trailer_reg     <= trailer_next;
            end
        end
    end

endmodule

@@ src/crc16_frame_checker_unit.sv @@
// ============================================================================
// crc16_frame_checker_unit
// CRC-16 frame checker: one verdict per burst, on the byte marked tlast.
//
//  channel  dir  width  contents
//  s_*      in   8+1    tdata: data_byte[7:0]; tlast: last_byte
//  m_*      out  48     tdata: verdict[1:0], computed_crc[17:2],
//                       received_crc[33:18], burst_length[40:34], zero pad
//  apb      in   3/32   crc_seed at address 0
//
//  One byte per cycle while s_tready is high; burst state updates on each take.
//  The verdict appears on m_* the cycle after the last byte is taken.
//  s_tready drops only while a verdict waits and m_tready is low.
//  Reset clears burst state and sets crc_seed to 0xFFFF.
// ============================================================================
module crc16_frame_checker_unit #(
    parameter int FRAME_BYTES  = crc16fc_pkg::FRAME_BYTES_DEF,
    parameter int BUFFER_BYTES = crc16fc_pkg::BUFFER_BYTES_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [crc16fc_pkg::DATA_W-1:0]        s_tdata,   // data_byte
    input  logic                                  s_tlast,   // last_byte
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [crc16fc_pkg::OUT_TDATA_W-1:0]   m_tdata,   // verdict, computed_crc,
                                                             // received_crc, burst_length
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [crc16fc_pkg::CFG_ADDR_W-1:0]    paddr,
    input  logic [crc16fc_pkg::CFG_DATA_W-1:0]    pwdata,
    output logic [crc16fc_pkg::CFG_DATA_W-1:0]    prdata,
    output logic                                  pready
);
    import crc16fc_pkg::*;

    logic [CRC_W-1:0] seed_reg;
    logic             out_valid_reg;
    result_t          out_data_reg;
    result_t          track_result;
    logic             take;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_CRC_SEED) ? CFG_DATA_W'(seed_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            seed_reg <= CRC_SEED_RESET;
        else if (psel && penable && pwrite && pready && (paddr[2] == REG_CRC_SEED))
            seed_reg <= pwdata[CRC_W-1:0];
    end

    assign s_tready = !out_valid_reg || m_tready;
    assign take     = s_tvalid && s_tready;

    crc16fc_track #(
        .FRAME_BYTES  (FRAME_BYTES),
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_track (
        .clk       (clk),
        .rst_n     (rst_n),
        .seed      (seed_reg),
        .advance   (take),
        .data_byte (s_tdata),
        .last_byte (s_tlast),
        .result    (track_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (take && s_tlast)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (take && s_tlast)
            out_data_reg <= track_result;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_TDATA_W'(out_data_reg);

    // a held verdict blocks the input side
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_tready) |-> !s_tready)
        else $error("input taken while verdict stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (out_data_reg.verdict == VERDICT_ACCEPTED)) |->
            (out_data_reg.computed_crc == out_data_reg.received_crc))
        else $error("accepted frame with CRC mismatch");

    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (out_data_reg.verdict != VERDICT_BAD_LEN)) |->
            (out_data_reg.burst_length == BURST_LEN_W'(FRAME_BYTES)))
        else $error("length passed with wrong burst length");

    assert property (@(posedge clk) disable iff (!rst_n)
        (take && s_tlast) |=> m_tvalid)
        else $error("last byte gave no verdict");

endmodule
